// ===== rtl/smpd_pkg.sv =====
`default_nettype none
package smpd_pkg;

  localparam int ACC_WIDTH_DEF   = 16;
  localparam int NUM_BUTTONS_DEF = 2;
  localparam int MAX_BUTTONS     = 2;
  localparam int SYNC_BIT        = 6;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_POLL = 1'b1;

  localparam logic [1:0] EV_DOWN   = 2'd0;
  localparam logic [1:0] EV_UP     = 2'd1;
  localparam logic [1:0] EV_MOTION = 2'd2;

  typedef struct packed {
    logic       operation;
    logic [7:0] serial_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         event_kind;
    logic               button_index;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic               last;
  } out_item_t;

  // one poll's worth of work handed from front to back
  typedef struct packed {
    logic [MAX_BUTTONS-1:0] btn_change;
    logic [MAX_BUTTONS-1:0] btn_state;
    logic                   motion;
    logic signed [15:0]     dx;
    logic signed [15:0]     dy;
  } job_t;

endpackage
`default_nettype wire

// ===== rtl/smpd_front.sv =====
`default_nettype none
module smpd_front import smpd_pkg::*; #(
  parameter int ACC_WIDTH   = ACC_WIDTH_DEF,
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     cfg_wr_en,
  input  wire logic     cfg_wr_data,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  input  wire logic     q_full,
  output logic          q_push,
  output job_t          q_job
);

  localparam logic [MAX_BUTTONS-1:0] BTN_MASK =
    MAX_BUTTONS'((1 << NUM_BUTTONS) - 1);
  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  logic                        enable_r;
  logic [1:0]                  pos_r, pos_nxt;
  logic [7:0]                  header_r, header_nxt;
  logic [7:0]                  xlow_r, xlow_nxt;
  logic signed [ACC_WIDTH-1:0] acc_x_r, acc_x_nxt;
  logic signed [ACC_WIDTH-1:0] acc_y_r, acc_y_nxt;
  logic [MAX_BUTTONS-1:0]      btn_r, btn_nxt;
  logic [MAX_BUTTONS-1:0]      rep_r, rep_nxt;

  logic                        accept;
  logic [1:0]                  pos_eff;
  logic [7:0]                  dx8, dy8;
  logic signed [ACC_WIDTH:0]   sum_x, sum_y;
  logic signed [ACC_WIDTH-1:0] neg_y;
  logic signed [31:0]          ext_x, ext_y;
  logic [MAX_BUTTONS-1:0]      changed;
  logic                        has_motion;

  function automatic logic signed [ACC_WIDTH-1:0] sat(input logic signed [ACC_WIDTH:0] s);
    logic signed [ACC_WIDTH-1:0] r;
    if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) begin
      r = s[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
    end else begin
      r = s[ACC_WIDTH-1:0];
    end
    return r;
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    dx8   = {header_r[1:0], 6'b0} + xlow_r;
    dy8   = {header_r[3:2], 6'b0} + in_data.serial_byte;
    sum_x = {acc_x_r[ACC_WIDTH-1], acc_x_r} + (ACC_WIDTH+1)'($signed(dx8));
    sum_y = {acc_y_r[ACC_WIDTH-1], acc_y_r} + (ACC_WIDTH+1)'($signed(dy8));
    neg_y = (acc_y_r == ACC_MIN) ? ACC_MAX : -acc_y_r;
    ext_x = 32'(acc_x_r);
    ext_y = 32'(neg_y);
    changed    = (btn_r ^ rep_r) & BTN_MASK;
    has_motion = (acc_x_r != '0) || (acc_y_r != '0);

    q_job.btn_change = changed;
    q_job.btn_state  = btn_r;
    q_job.motion     = has_motion;
    q_job.dx         = ext_x[15:0];
    q_job.dy         = ext_y[15:0];
    q_push = accept && (in_data.operation == OP_POLL) && enable_r &&
             ((changed != '0) || has_motion);
  end

  always_comb begin
    pos_nxt    = pos_r;
    header_nxt = header_r;
    xlow_nxt   = xlow_r;
    acc_x_nxt  = acc_x_r;
    acc_y_nxt  = acc_y_r;
    btn_nxt    = btn_r;
    rep_nxt    = rep_r;
    pos_eff    = in_data.serial_byte[SYNC_BIT] ? 2'd0 : pos_r;
    if (accept) begin
      if (in_data.operation == OP_BYTE) begin
        case (pos_eff)
          2'd0: begin
            header_nxt = in_data.serial_byte;
            pos_nxt    = 2'd1;
          end
          2'd1: begin
            xlow_nxt = in_data.serial_byte;
            pos_nxt  = 2'd2;
          end
          default: begin
            acc_x_nxt = sat(sum_x);
            acc_y_nxt = sat(sum_y);
            btn_nxt   = header_r[5:4];
            pos_nxt   = 2'd0;
          end
        endcase
      end else if (enable_r) begin
        rep_nxt = btn_r;
        if (has_motion) begin
          acc_x_nxt = '0;
          acc_y_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      pos_r    <= '0;
      header_r <= '0;
      xlow_r   <= '0;
      acc_x_r  <= '0;
      acc_y_r  <= '0;
      btn_r    <= '0;
      rep_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        enable_r <= cfg_wr_data;
      end
      pos_r    <= pos_nxt;
      header_r <= header_nxt;
      xlow_r   <= xlow_nxt;
      acc_x_r  <= acc_x_nxt;
      acc_y_r  <= acc_y_nxt;
      btn_r    <= btn_nxt;
      rep_r    <= rep_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/smpd_queue.sv =====
`default_nettype none
module smpd_queue import smpd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output job_t      head_job
);

  job_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push, do_pop;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/smpd_back.sv =====
`default_nettype none
module smpd_back import smpd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic head_valid,
  input  wire job_t head_job,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_item_t out_data
);

  // pending bits: button 0, button 1, motion
  logic [2:0] done_r, done_nxt;
  logic [2:0] pend;
  logic       out_valid_r;
  out_item_t  out_data_r, out_data_nxt;
  logic       load;
  logic       is_last;
  logic [2:0] pick;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign load      = head_valid && (!out_valid_r || out_ready);

  always_comb begin
    pend = {head_job.motion, head_job.btn_change} & ~done_r;
    out_data_nxt = '0;
    pick = 3'b000;
    if (pend[0]) begin
      pick = 3'b001;
      out_data_nxt.event_kind   = head_job.btn_state[0] ? EV_DOWN : EV_UP;
      out_data_nxt.button_index = 1'b0;
    end else if (pend[1]) begin
      pick = 3'b010;
      out_data_nxt.event_kind   = head_job.btn_state[1] ? EV_DOWN : EV_UP;
      out_data_nxt.button_index = 1'b1;
    end else begin
      pick = 3'b100;
      out_data_nxt.event_kind = EV_MOTION;
      out_data_nxt.delta_x    = head_job.dx;
      out_data_nxt.delta_y    = head_job.dy;
    end
    is_last = ((pend & ~pick) == 3'b000);
    out_data_nxt.last = is_last;
    pop = load && is_last;
    done_nxt = done_r;
    if (load) begin
      done_nxt = is_last ? 3'b000 : (done_r | pick);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/serial_mouse_packet_decoder_core.sv =====
`default_nettype none
// Three-byte serial mouse decoder. Serial bytes and polls are taken one per cycle;
// bytes update the frame state and saturating motion accumulators straight away,
// and an enabled poll with something to report queues one job (two-entry queue)
// that the output side turns into one event per cycle while out_ready stays high:
// button 0, button 1, then motion, with last set on the final one. A poll thus
// yields 0 to 3 events; the input, bytes included, stalls only while the queue
// holds two unfinished polls, which back-pressure on the output can bring about.
module serial_mouse_packet_decoder_core import smpd_pkg::*; #(
  parameter int ACC_WIDTH   = ACC_WIDTH_DEF,
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      cfg_wr_en,
  input  wire logic      cfg_wr_data,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  logic q_full, q_push, q_pop, q_head_valid;
  job_t q_job, q_head;

  smpd_front #(
    .ACC_WIDTH   (ACC_WIDTH),
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_job       (q_job)
  );

  smpd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (q_head)
  );

  smpd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_job   (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

// ===== test/smpd_checker.sv =====
module smpd_checker import smpd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        mismatches,
  output int        events_waiting,
  output int        button_events,
  output int        motion_events
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ACC_MAX = 32767;
  localparam int ACC_MIN = -32768;

  logic       mouse_on;
  logic [1:0] frame_pos;
  logic [7:0] header_q;
  logic [7:0] x_byte_q;
  int         acc_x;
  int         acc_y;
  logic [1:0] buttons_latched;
  logic [1:0] buttons_reported;
  out_item_t  event_q[$];

  function automatic int sat_add(int acc, int delta);
    int s;
    s = acc + delta;
    if (s > ACC_MAX) return ACC_MAX;
    if (s < ACC_MIN) return ACC_MIN;
    return s;
  endfunction

  function automatic out_item_t make_event(logic [1:0] kind, logic idx, int dx, int dy);
    out_item_t ev;
    ev.event_kind   = kind;
    ev.button_index = idx;
    ev.delta_x      = dx[15:0];
    ev.delta_y      = dy[15:0];
    ev.last         = 1'b0;
    return ev;
  endfunction

  // works out the events that one input transfer causes
  task automatic decode_transfer(in_item_t it);
    logic [7:0] dx8;
    logic [7:0] dy8;
    logic [1:0] changed;
    out_item_t  evs[3];
    int         n;
    n = 0;
    if (it.operation == OP_BYTE) begin
      if (it.serial_byte[SYNC_BIT]) frame_pos = 2'd0;
      case (frame_pos)
        2'd0: begin
          header_q  = it.serial_byte;
          frame_pos = 2'd1;
        end
        2'd1: begin
          x_byte_q  = it.serial_byte;
          frame_pos = 2'd2;
        end
        default: begin
          // top bits of each delta come from the header, sum wraps to 8 bits
          dx8 = {header_q[1:0], 6'b0} + x_byte_q;
          dy8 = {header_q[3:2], 6'b0} + it.serial_byte;
          acc_x = sat_add(acc_x, $signed(dx8));
          acc_y = sat_add(acc_y, $signed(dy8));
          buttons_latched = header_q[5:4];
          frame_pos = 2'd0;
        end
      endcase
    end else if (mouse_on) begin
      changed = buttons_latched ^ buttons_reported;
      buttons_reported = buttons_latched;
      for (int i = 0; i < 2; i++) begin
        if (changed[i]) begin
          evs[n] = make_event(buttons_latched[i] ? EV_DOWN : EV_UP, i[0], 0, 0);
          n++;
        end
      end
      if (acc_x != 0 || acc_y != 0) begin
        // y is reported negated, the most negative value clips
        evs[n] = make_event(EV_MOTION, 1'b0, acc_x, (acc_y == ACC_MIN) ? ACC_MAX : -acc_y);
        n++;
        acc_x = 0;
        acc_y = 0;
      end
      if (n > 0) evs[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) event_q.push_back(evs[i]);
    end
  endtask

  task automatic note_mismatch(string what, out_item_t want, out_item_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected kind %0d btn %0d dx %0d dy %0d last %0d, got kind %0d btn %0d dx %0d dy %0d last %0d",
               $time, what, want.event_kind, want.button_index, want.delta_x, want.delta_y,
               want.last, got.event_kind, got.button_index, got.delta_x, got.delta_y, got.last);
  endtask

  initial begin
    mismatches     = 0;
    events_waiting = 0;
    button_events  = 0;
    motion_events  = 0;
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      mouse_on         = 1'b0;
      frame_pos        = 2'd0;
      header_q         = 8'd0;
      x_byte_q         = 8'd0;
      acc_x            = 0;
      acc_y            = 0;
      buttons_latched  = 2'd0;
      buttons_reported = 2'd0;
      event_q.delete();
    end else begin
      if (cfg_wr_en) mouse_on = cfg_wr_data;
      if (in_valid && in_ready) decode_transfer(in_data);
      if (out_valid && out_ready) begin
        if (event_q.size() == 0) begin
          note_mismatch("event with none outstanding", '0, out_data);
        end else begin
          want = event_q.pop_front();
          if (out_data.event_kind !== want.event_kind ||
              out_data.button_index !== want.button_index ||
              out_data.delta_x !== want.delta_x ||
              out_data.delta_y !== want.delta_y ||
              out_data.last !== want.last)
            note_mismatch("event mismatch", want, out_data);
          if (want.event_kind == EV_MOTION) motion_events++;
          else button_events++;
        end
      end
    end
    events_waiting <= event_q.size();
  end

endmodule

// ===== test/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import smpd_pkg::*;

  localparam int ACC_FRAMES   = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 40;
  localparam int SETTLE       = 8;
  localparam int CYCLE_LIMIT  = 400000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_wr_en = 1'b0;
  logic      cfg_wr_data = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int mismatches;
  int events_waiting;
  int button_events;
  int motion_events;

  int   items_sent = 0;
  int   in_idle_pct = 0;
  int   out_stall_pct = 0;
  int   cycle_count = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int   hold_count = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  serial_mouse_packet_decoder_core u_top (
    .clk,
    .rst_n,
    .cfg_wr_en,
    .cfg_wr_data,
    .in_valid,
    .in_ready,
    .in_data,
    .out_valid,
    .out_ready,
    .out_data
  );

  smpd_checker u_checker (
    .clk,
    .rst_n,
    .cfg_wr_en,
    .cfg_wr_data,
    .in_valid,
    .in_ready,
    .in_data,
    .out_valid,
    .out_ready,
    .out_data,
    .mismatches,
    .events_waiting,
    .button_events,
    .motion_events
  );

  // receiver: random stalls, or a long hold-off while hold_req is up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      hold_count <= 0;
      hold_done  <= 1'b0;
    end else if (hold_req && !hold_done) begin
      out_ready  <= 1'b0;
      hold_count <= hold_count + 1;
      if (hold_count == HOLD_CYCLES - 1) hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= out_stall_pct);
      if (!hold_req) begin
        hold_count <= 0;
        hold_done  <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timed out after %0d cycles", cycle_count);
      $display("serial_mouse_packet_decoder_core regression: fail");
      $finish;
    end
  end

  // valid stays up across back-to-back transfers, only a gap lowers it
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(in_item_t'{OP_BYTE, b});
  endtask

  task automatic send_poll();
    send_item(in_item_t'{OP_POLL, 8'($urandom)});
  endtask

  task automatic send_frame(logic [7:0] head, logic [7:0] xb, logic [7:0] yb);
    send_byte(head);
    send_byte(xb);
    send_byte(yb);
  endtask

  function automatic logic [7:0] header_byte();
    return {1'($urandom), 1'b1, 6'($urandom)};
  endfunction

  function automatic logic [7:0] data_byte();
    return {1'($urandom), 1'b0, 6'($urandom)};
  endfunction

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (events_waiting != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_enable(logic value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // mostly clean frames and polls, some truncated frames and stray bytes
  task automatic send_random_sequence();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) begin
      send_frame(header_byte(), data_byte(), data_byte());
      if ($urandom_range(1) == 1) send_poll();
    end else if (pick < 75) begin
      send_poll();
    end else if (pick < 88) begin
      send_byte(header_byte());
      if ($urandom_range(1) == 1) send_byte(data_byte());
    end else begin
      send_byte(8'($urandom));
    end
  endtask

  initial begin
    int start;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // bytes still decode while disabled, polls stay silent
    send_poll();
    send_frame(8'h7F, 8'h3F, 8'h3F);
    send_poll();
    write_enable(1'b1);
    send_poll();
    send_poll();
    send_frame(8'h40, 8'h00, 8'h00);
    send_poll();
    // full positive x, most negative y
    send_frame(8'h69, 8'h3F, 8'h00);
    send_poll();
    // sync byte mid-frame restarts it
    send_byte(8'h40);
    send_frame(8'h50, 8'h01, 8'h02);
    send_poll();
    // delta sum wraps past 8 bits
    send_frame(8'h4F, 8'hBF, 8'hBF);
    send_poll();

    // long run of the largest deltas builds up both accumulators
    for (int k = 0; k < ACC_FRAMES; k++) send_frame(8'h49, 8'h3F, 8'h00);
    send_poll();

    // hold the output off so polls back up and the input stalls
    hold_req <= 1'b1;
    for (int k = 0; k < 8; k++) begin
      send_frame(header_byte(), data_byte(), data_byte());
      send_poll();
    end
    while (!hold_done) @(posedge clk);
    hold_req <= 1'b0;
    wait_idle();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 77; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 77; end
        default: begin in_idle_pct = 37; out_stall_pct = 37; end
      endcase
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) send_random_sequence();
      if (p == 1) begin
        // motion piles up while disabled and comes out once re-enabled
        write_enable(1'b0);
        for (int k = 0; k < 10; k++) send_random_sequence();
        write_enable(1'b1);
      end
    end

    wait_idle();
    $display("covered %0d input transfers: directed cases, a %0d-frame accumulation run,",
             items_sent, ACC_FRAMES);
    $display("  a %0d-cycle hold-off and four idling mixes", HOLD_CYCLES);
    $display("checked %0d button and %0d motion events, %0d mismatches, %0d undelivered",
             button_events, motion_events, mismatches, events_waiting);
    if (mismatches == 0 && events_waiting == 0)
      $display("serial_mouse_packet_decoder_core regression: pass");
    else
      $display("serial_mouse_packet_decoder_core regression: fail");
    $finish;
  end

endmodule
